[hdl/rsw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rsw_pkg;

    // Default sizes for the top level parameters
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_ITER   = 15;
    localparam int DEF_FRAC_BITS  = 16;

    // Configuration port
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATIONS   = 2'd2;

    // Item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_WARP = 1'b1;

    // Odd Taylor coefficients of sin(t*pi/2), Q30
    localparam logic [30:0] Q30_ONE = 31'd1073741824;
    localparam logic [30:0] SIN_C1  = 31'd1686629713;
    localparam logic [30:0] SIN_C3  = 31'd693598668;
    localparam logic [30:0] SIN_C5  = 31'd85569306;
    localparam logic [30:0] SIN_C7  = 31'd5026995;
    localparam logic [30:0] SIN_C9  = 31'd172272;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RHO,
        ST_RHO_WAIT,
        ST_SQRT,
        ST_SIN_PREP,
        ST_SIN_MUL,
        ST_MAP_START,
        ST_MAP_WAIT,
        ST_MAP_EVAL,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

[hdl/rsw_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module rsw_div #(
    parameter int NUM_W = 51,
    parameter int DEN_W = 19
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0] shifted;
    logic [DEN_W:0] diff;
    logic           ge;

    // one restoring step: shift in the next numerator bit, subtract if it fits
    assign shifted = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
    assign ge      = (shifted >= {1'b0, r_den});
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff : shifted;
            r_num <= {r_num[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule

`default_nettype wire

[hdl/radial_sine_warp.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                    Payload
// -------   ---------  ---------------------------  ------------------------------------
// in        sink       i_in_valid / o_in_ready      i_func i_col_x i_row_y i_pixel_in
// out       source     o_out_valid / i_out_ready    o_pixel_out o_outside
// cfg       sink       i_cfg_we (no wait)           i_cfg_idx i_cfg_data
//
// A load transfer writes the image store directly; the next item is taken at once.
// A warp item runs the bit-serial divider up to three times (radius, then one per axis),
// the bit-serial square root and the shared multiplier of the sine, six products per
// iteration; no new item is taken until its result is placed in the output register.
// Reset clears the sequencer, the output valid and restores the configuration registers;
// the image store keeps its contents and is undefined until loaded.
// A finished result waits in the output register; the next item is taken while it waits,
// and a second result holds in the last state until the register drains.

module radial_sine_warp import rsw_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_ITER   = DEF_MAX_ITER,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item input
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_func,
    input  logic [7:0]            i_col_x,
    input  logic [7:0]            i_row_y,
    input  logic [23:0]           i_pixel_in,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [23:0]           o_pixel_out,
    output logic                  o_outside,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int F      = FRAC_BITS;
    localparam int RW     = F + 2;              // radius, Q2.F
    localparam int QW     = 2 * F + 4;          // squared radius, before the root
    localparam int NUM_W  = 2 * F + 19;         // divider numerator
    localparam int DEN_W  = (F + 2 > 19) ? F + 2 : 19;
    localparam int POS_W  = NUM_W + 1;
    localparam int SH     = 30 - F;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);

    localparam logic [8:0]    W_CAP   = 9'((MAX_WIDTH > 511) ? 511 : MAX_WIDTH);
    localparam logic [8:0]    H_CAP   = 9'((MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT);
    localparam logic [3:0]    IT_CAP  = 4'((MAX_ITER > 15) ? 15 : MAX_ITER);
    localparam logic [12:0]   MW13    = 13'(MAX_WIDTH);
    localparam logic [12:0]   MH13    = 13'(MAX_HEIGHT);
    localparam logic [RW-1:0] ONE_Q   = RW'(1) << F;
    localparam logic [RW-1:0] TWO_Q   = RW'(2) << F;
    localparam logic [RW-1:0] RHO_MAX = {RW{1'b1}};
    localparam logic [30:0]   RND     = 31'(1) << (29 - F);
    localparam logic [QW-1:0] SQ_TOP  = QW'(1) << (2 * F + 2);

    // ---------------------------------------------------------------- registers
    t_state              r_state, n_state;

    logic [8:0]          r_cfg_w, r_cfg_h;
    logic [3:0]          r_cfg_it;

    logic [8:0]          r_w, r_h;
    logic [3:0]          r_it;
    logic                r_dx_neg, r_dy_neg;
    logic [8:0]          r_dmx, r_dmy;
    logic [18:0]         r_sum, r_den;
    logic [RW-1:0]       r_rho;
    logic [QW-1:0]       r_sq_v, r_sq_res, r_sq_bit;
    logic [RW-1:0]       r_mag;
    logic                r_neg;
    logic [30:0]         r_t30, r_t2, r_acc;
    logic [2:0]          r_mstep;
    logic                r_axis;
    logic [NUM_W-1:0]    r_q;
    logic [8:0]          r_px, r_py;
    logic                r_inx, r_iny;
    logic [23:0]         r_rd;
    logic                r_out_valid;
    logic [23:0]         r_pixel_out;
    logic                r_outside;

    logic [23:0]         mem [DEPTH];

    // ---------------------------------------------------------------- input side
    logic               in_xfer;
    logic [8:0]         w_c, h_c;
    logic [3:0]         it_c;
    logic signed [10:0] dx2, dy2;
    logic [AW-1:0]      ld_addr;
    logic               ld_ok;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;

    // clamp sizes and iteration count to their legal ranges
    assign w_c  = (r_cfg_w == 9'd0) ? 9'd1 : ((r_cfg_w > W_CAP) ? W_CAP : r_cfg_w);
    assign h_c  = (r_cfg_h == 9'd0) ? 9'd1 : ((r_cfg_h > H_CAP) ? H_CAP : r_cfg_h);
    assign it_c = (r_cfg_it == 4'd0) ? 4'd1 : ((r_cfg_it > IT_CAP) ? IT_CAP : r_cfg_it);

    // offsets from the centre in half pixels
    assign dx2 = $signed({2'b00, i_col_x, 1'b0}) - $signed({2'b00, w_c});
    assign dy2 = $signed({2'b00, i_row_y, 1'b0}) - $signed({2'b00, h_c});

    assign ld_addr = AW'(i_row_y) * AW'(MAX_WIDTH) + AW'(i_col_x);
    assign ld_ok   = (13'(i_col_x) < MW13) && (13'(i_row_y) < MH13);

    // ---------------------------------------------------------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= 9'd256;
            r_cfg_h  <= 9'd256;
            r_cfg_it <= 4'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_IMAGE_WIDTH) begin
                r_cfg_w <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_IMAGE_HEIGHT) begin
                r_cfg_h <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_ITERATIONS) begin
                r_cfg_it <= i_cfg_data[3:0];
            end
        end
    end

    // ---------------------------------------------------------------- divider
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [NUM_W-1:0] div_quo;

    rsw_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // ---------------------------------------------------------------- square root step
    logic [QW-1:0] sq_try;
    logic          sq_fit;
    logic [RW-1:0] rho_root;

    assign sq_try   = r_sq_res + r_sq_bit;
    assign sq_fit   = (r_sq_v >= sq_try);
    assign rho_root = (|r_sq_res[QW-1:RW]) ? RHO_MAX : r_sq_res[RW-1:0];

    // ---------------------------------------------------------------- sine datapath
    logic [RW-1:0] red1, red2;
    logic          red_flip;
    logic [30:0]   mul_a, mul_b;
    logic [61:0]   prod;
    logic [30:0]   psh;
    logic [30:0]   coef;
    logic [30:0]   sin_clamp;
    logic [30:0]   sin_rnd;
    logic [F:0]    sin_res;

    // fold the argument into [0,1], carrying the sign apart
    assign red_flip = (r_mag >= TWO_Q);
    assign red1     = red_flip ? (r_mag - TWO_Q) : r_mag;
    assign red2     = (red1 > ONE_Q) ? (TWO_Q - red1) : red1;

    // shared multiplier: t^2 first, then the Horner steps, then the final product by t
    assign mul_a = (r_mstep == 3'd0) ? r_t30 : r_acc;
    assign mul_b = ((r_mstep == 3'd0) || (r_mstep == 3'd5)) ? r_t30 : r_t2;
    assign prod  = mul_a * mul_b;
    assign psh   = prod[60:30];

    always_comb begin
        unique case (r_mstep)
            3'd1:    coef = SIN_C7;
            3'd2:    coef = SIN_C5;
            3'd3:    coef = SIN_C3;
            default: coef = SIN_C1;
        endcase
    end

    // cap at one and round half up to F fraction bits
    assign sin_clamp = (psh > Q30_ONE) ? Q30_ONE : psh;
    assign sin_rnd   = sin_clamp + RND;
    assign sin_res   = sin_rnd[30:SH];

    // ---------------------------------------------------------------- axis mapping
    logic [8:0]       ax_dm;
    logic [8:0]       ax_size;
    logic             ax_neg;
    logic [POS_W-1:0] ax_base, ax_lim, ax_q, ax_pos;
    logic [8:0]       ax_pix;
    logic             ax_in;

    assign ax_dm   = r_axis ? r_dmy : r_dmx;
    assign ax_size = r_axis ? r_h : r_w;
    assign ax_neg  = (r_axis ? r_dy_neg : r_dx_neg) ^ r_neg;
    assign ax_base = POS_W'(ax_size) << F;
    assign ax_lim  = POS_W'(ax_size) << (F + 1);
    assign ax_q    = POS_W'(r_q);

    always_comb begin
        ax_pos = '0;
        ax_pix = '0;
        ax_in  = 1'b0;
        priority if (!ax_neg) begin
            ax_pos = ax_base + ax_q;
            ax_pix = ax_pos[F+9:F+1];
            ax_in  = (ax_pos < ax_lim);
        end else if (ax_q <= ax_base) begin
            ax_pos = ax_base - ax_q;
            ax_pix = ax_pos[F+9:F+1];
            ax_in  = (ax_pos < ax_lim);
        end else begin
            // just left of the edge still truncates to pixel zero
            ax_pix = '0;
            ax_in  = ((ax_q - ax_base) < (POS_W'(1) << (F + 1)));
        end
    end

    // ---------------------------------------------------------------- sequencer
    logic out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_num   = NUM_W'(r_sum) << (2 * F);
        div_den   = DEN_W'(r_den);
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && (i_func == FUNC_WARP)) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = ST_RHO;
            end
            ST_RHO: begin
                if ({4'b0, r_sum} >= {r_den, 4'b0}) begin
                    n_state = ST_SIN_PREP;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_RHO_WAIT;
                end
            end
            ST_RHO_WAIT: begin
                if (div_done) begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (r_sq_bit == '0) begin
                    n_state = ST_SIN_PREP;
                end
            end
            ST_SIN_PREP: begin
                n_state = ST_SIN_MUL;
            end
            ST_SIN_MUL: begin
                if (r_mstep == 3'd5) begin
                    n_state = (r_it == 4'd1) ? ST_MAP_START : ST_SIN_PREP;
                end
            end
            ST_MAP_START: begin
                div_num = (NUM_W'(ax_dm) * NUM_W'(r_mag)) << F;
                div_den = DEN_W'(r_rho);
                if (r_rho == '0) begin
                    n_state = ST_MAP_EVAL;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_MAP_WAIT;
                end
            end
            ST_MAP_WAIT: begin
                if (div_done) begin
                    n_state = ST_MAP_EVAL;
                end
            end
            ST_MAP_EVAL: begin
                n_state = r_axis ? ST_READ : ST_MAP_START;
            end
            ST_READ: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                // latch the item and the clamped configuration
                r_w      <= w_c;
                r_h      <= h_c;
                r_it     <= it_c;
                r_dx_neg <= dx2[10];
                r_dy_neg <= dy2[10];
                r_dmx    <= dx2[10] ? 9'(-dx2) : 9'(dx2);
                r_dmy    <= dy2[10] ? 9'(-dy2) : 9'(dy2);
            end
            ST_SETUP: begin
                r_sum <= 19'(18'(r_dmx * r_dmx)) + 19'(18'(r_dmy * r_dmy));
                r_den <= 19'(18'(r_w * r_w)) + 19'(18'(r_h * r_h));
            end
            ST_RHO: begin
                // radius saturates just under four
                r_rho <= RHO_MAX;
                r_mag <= RHO_MAX;
                r_neg <= 1'b0;
            end
            ST_RHO_WAIT: begin
                r_sq_v   <= div_quo[QW-1:0];
                r_sq_res <= '0;
                r_sq_bit <= SQ_TOP;
            end
            ST_SQRT: begin
                if (r_sq_bit == '0) begin
                    r_rho <= rho_root;
                    r_mag <= rho_root;
                    r_neg <= 1'b0;
                end else begin
                    if (sq_fit) begin
                        r_sq_v   <= r_sq_v - sq_try;
                        r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                    end else begin
                        r_sq_res <= r_sq_res >> 1;
                    end
                    r_sq_bit <= r_sq_bit >> 2;
                end
            end
            ST_SIN_PREP: begin
                r_t30   <= 31'(red2) << SH;
                r_mstep <= 3'd0;
                if (red_flip) begin
                    r_neg <= !r_neg;
                end
            end
            ST_SIN_MUL: begin
                r_mstep <= r_mstep + 3'd1;
                if (r_mstep == 3'd0) begin
                    r_t2  <= psh;
                    r_acc <= SIN_C9;
                end else if (r_mstep == 3'd5) begin
                    r_mag  <= RW'(sin_res);
                    r_it   <= r_it - 4'd1;
                    r_axis <= 1'b0;
                    if (sin_res == '0) begin
                        r_neg <= 1'b0;
                    end
                end else begin
                    r_acc <= coef - psh;
                end
            end
            ST_MAP_START: begin
                // centre pixel keeps its offset
                r_q <= NUM_W'(ax_dm) << F;
            end
            ST_MAP_WAIT: begin
                r_q <= div_quo;
            end
            ST_MAP_EVAL: begin
                r_axis <= 1'b1;
                if (r_axis) begin
                    r_py  <= ax_pix;
                    r_iny <= ax_in;
                end else begin
                    r_px  <= ax_pix;
                    r_inx <= ax_in;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------- image store
    always_ff @(posedge i_clk) begin
        if (in_xfer && (i_func == FUNC_LOAD) && ld_ok) begin
            mem[ld_addr] <= i_pixel_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_rd <= mem[AW'(r_py) * AW'(MAX_WIDTH) + AW'(r_px)];
        end
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_pixel_out <= (r_inx && r_iny) ? r_rd : 24'd0;
            r_outside   <= !(r_inx && r_iny);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_pixel_out;
    assign o_outside   = r_outside;

endmodule

`default_nettype wire
